/* src/fem_pkg.sv */
// Shared types, constants and codes for the feature exclusion mask block.
// No dependencies; imported by fem_front, fem_queue, fem_back and the top level.
package fem_pkg;

    // Store geometry
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int WORD_BITS   = 32;
    localparam int ROW_WORDS   = (MAX_WIDTH + WORD_BITS - 1) / WORD_BITS;
    localparam int STORE_DEPTH = MAX_HEIGHT * ROW_WORDS;

    localparam int OFF_W  = $clog2(WORD_BITS);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WIDX_W = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // Fixed field widths
    localparam int CFG_W     = 11;
    localparam int PATCH_W   = 6;
    localparam int COORD_W   = 13;
    localparam int RROW_W    = 10;
    localparam int RWORD_W   = 5;
    localparam int OUT_W     = 32;
    localparam int S_W       = 15;   // signed width for bound arithmetic

    localparam int QUEUE_DEPTH = 2;
    localparam int QP_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_W-1:0]   WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0]   HEIGHT_RESET = CFG_W'(480);
    localparam logic [PATCH_W-1:0] PATCH_RESET  = PATCH_W'(5);

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_PATCH_HALF   = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        B_IDLE     = 3'd0,
        B_CLEAR    = 3'd1,
        B_ADD      = 3'd2,
        B_RD_ISSUE = 3'd3,
        B_RD_OUT   = 3'd4
    } back_state_t;

    // One queued job, fully decoded by the front end
    typedef struct packed {
        op_t               op;
        logic [ROW_W-1:0]  r0;
        logic [ROW_W-1:0]  r1;
        logic [WIDX_W-1:0] wd0;
        logic [WIDX_W-1:0] wd1;
        logic [OFF_W-1:0]  off0;
        logic [OFF_W-1:0]  off1;
        logic [ADDR_W-1:0] read_addr;
        logic              read_oob;
    } task_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    typedef struct packed {
        logic init;   // power-up clearing pass still running
    } back_status_t;

endpackage

/* src/fem_front.sv */
// Front end: config registers, command decode and patch bound computation.
// Depends on fem_pkg; feeds fem_queue.
module fem_front
    import fem_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic [1:0]                command,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic [RROW_W-1:0]         read_row,
    input  logic [RWORD_W-1:0]        read_word,
    input  logic                      cfg_write,
    input  logic [1:0]                cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    output logic                      push,
    output task_t                     entry
);

    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic [PATCH_W-1:0] patch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            patch_reg  <= PATCH_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                CFG_PATCH_HALF:   patch_reg  <= cfg_data[PATCH_W-1:0];
                default:          ;
            endcase
        end
    end

    logic [CFG_W-1:0]        w_eff, h_eff;
    logic signed [S_W-1:0]   px_s, py_s, w_s, h_s, p_s, w_m1, h_m1;
    logic signed [S_W-1:0]   lo_x, hi_x, lo_y, hi_y, c0_s, c1_s, r0_s, r1_s;
    logic [COL_W-1:0]        c0, c1;
    logic                    skip;
    logic                    accept;

    always_comb
    begin
        w_eff = (32'(width_reg) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : width_reg;
        h_eff = (32'(height_reg) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : height_reg;
        px_s  = S_W'(point_x);
        py_s  = S_W'(point_y);
        w_s   = S_W'(w_eff);
        h_s   = S_W'(h_eff);
        p_s   = S_W'(patch_reg);
        w_m1  = w_s - S_W'(1);
        h_m1  = h_s - S_W'(1);

        // coordinate 0 counts as an edge, like a negative one
        skip = px_s[S_W-1] || (px_s == '0) || (px_s >= w_s) ||
               py_s[S_W-1] || (py_s == '0) || (py_s >= h_s);

        lo_x = px_s - p_s;
        hi_x = px_s + p_s;
        lo_y = py_s - p_s;
        hi_y = py_s + p_s;
        c0_s = lo_x[S_W-1] ? '0 : lo_x;
        c1_s = (hi_x > w_m1) ? w_m1 : hi_x;
        r0_s = lo_y[S_W-1] ? '0 : lo_y;
        r1_s = (hi_y > h_m1) ? h_m1 : hi_y;
        c0   = COL_W'(c0_s);
        c1   = COL_W'(c1_s);

        entry.op        = OP_CLEAR;
        entry.r0        = ROW_W'(r0_s);
        entry.r1        = ROW_W'(r1_s);
        entry.wd0       = WIDX_W'(c0 / WORD_BITS);
        entry.wd1       = WIDX_W'(c1 / WORD_BITS);
        entry.off0      = OFF_W'(c0 % WORD_BITS);
        entry.off1      = OFF_W'(c1 % WORD_BITS);
        entry.read_addr = ADDR_W'(ADDR_W'(read_row) * ADDR_W'(ROW_WORDS) +
                                  ADDR_W'(read_word));
        entry.read_oob  = (32'(read_row) >= MAX_HEIGHT) || (32'(read_word) >= ROW_WORDS);

        accept = start && !busy;
        case (cmd_t'(command))
            CMD_CLEAR:
            begin
                entry.op = OP_CLEAR;
                push     = accept;
            end
            CMD_ADD:
            begin
                entry.op = OP_ADD;
                push     = accept && !skip;
            end
            CMD_READ:
            begin
                entry.op = OP_READ;
                push     = accept;
            end
            default:  push = 1'b0;
        endcase
    end

endmodule

/* src/fem_queue.sv */
// Short job queue between the front end and the mask sequencer.
// Depends on fem_pkg.
module fem_queue
    import fem_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  task_t     push_entry,
    input  logic      pop,
    output task_t     head,
    output q_status_t status
);

    task_t           slot_reg [QUEUE_DEPTH];
    logic [QP_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QC_W-1:0] count_reg;
    logic            do_push, do_pop;

    assign status.full  = (count_reg == QC_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* src/fem_back.sv */
// Back end: mask memory and the sequencer for clear sweeps, patch
// read-modify-write and word reads. Depends on fem_pkg; fed by fem_queue.
module fem_back
    import fem_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  task_t            head,
    output logic             pop,
    output back_status_t     status,
    output logic             result_strobe,
    output logic [OUT_W-1:0] mask_word
);

    localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

    logic [WORD_BITS-1:0] mem [STORE_DEPTH];

    back_state_t          state_reg, state_next;
    task_t                cur_reg;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [WIDX_W-1:0]    wd_reg, wd_next;
    logic [ADDR_W-1:0]    clr_reg, clr_next;
    logic                 init_reg;
    logic                 wb_valid_reg;
    logic [ADDR_W-1:0]    wb_addr_reg;
    logic [WORD_BITS-1:0] wb_bits_reg;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 strobe_reg;
    logic [OUT_W-1:0]     mask_word_reg;

    logic                 cur_load, rd_en, issue_wb, init_done, cap_out;
    logic [ADDR_W-1:0]    rd_addr, word_addr;
    logic [OFF_W-1:0]     lo, hi;
    logic [WORD_BITS-1:0] bits;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic [63:0]          rd_wide;

    // cleared span of the word under the cursor
    always_comb
    begin
        word_addr = ADDR_W'(ADDR_W'(row_reg) * ADDR_W'(ROW_WORDS) + ADDR_W'(wd_reg));
        lo        = (wd_reg == cur_reg.wd0) ? cur_reg.off0 : '0;
        hi        = (wd_reg == cur_reg.wd1) ? cur_reg.off1 : OFF_W'(WORD_BITS - 1);
        bits      = (ONES >> (OFF_W'(WORD_BITS - 1) - hi)) & (ONES << lo);
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        wd_next    = wd_reg;
        clr_next   = clr_reg;
        cur_load   = 1'b0;
        pop        = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = word_addr;
        issue_wb   = 1'b0;
        init_done  = 1'b0;
        cap_out    = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    pop      = 1'b1;
                    cur_load = 1'b1;
                    row_next = head.r0;
                    wd_next  = head.wd0;
                    clr_next = '0;
                    case (head.op)
                        OP_CLEAR: state_next = B_CLEAR;
                        OP_ADD:   state_next = B_ADD;
                        OP_READ:  state_next = B_RD_ISSUE;
                        default:  state_next = B_IDLE;
                    endcase
                end
            end
            B_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    clr_next   = '0;
                    init_done  = 1'b1;
                    state_next = B_IDLE;
                end
            end
            B_ADD:
            begin
                // one word read per cycle; its masked write-back follows from the read register
                rd_en    = 1'b1;
                issue_wb = 1'b1;
                if (wd_reg == cur_reg.wd1)
                begin
                    if (row_reg == cur_reg.r1)
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                        wd_next  = cur_reg.wd0;
                    end
                end
                else
                begin
                    wd_next = wd_reg + 1'b1;
                end
            end
            B_RD_ISSUE:
            begin
                rd_en      = 1'b1;
                rd_addr    = cur_reg.read_addr;
                state_next = B_RD_OUT;
            end
            B_RD_OUT:
            begin
                cap_out    = 1'b1;
                state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    // sweep and write-back never overlap: the idle cycle separates them
    always_comb
    begin
        wr_en   = (state_reg == B_CLEAR) || wb_valid_reg;
        wr_addr = (state_reg == B_CLEAR) ? clr_reg : wb_addr_reg;
        wr_data = (state_reg == B_CLEAR) ? ONES : (rd_data_reg & ~wb_bits_reg);
        rd_wide = 64'(rd_data_reg);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cur_load)
        begin
            cur_reg <= head;
        end
        if (issue_wb)
        begin
            wb_addr_reg <= word_addr;
            wb_bits_reg <= bits;
        end
        if (cap_out)
        begin
            mask_word_reg <= cur_reg.read_oob ? '1 : rd_wide[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_CLEAR;
            row_reg      <= '0;
            wd_reg       <= '0;
            clr_reg      <= '0;
            init_reg     <= 1'b1;
            wb_valid_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            wd_reg       <= wd_next;
            clr_reg      <= clr_next;
            wb_valid_reg <= issue_wb;
            strobe_reg   <= cap_out;
            if (init_done)
            begin
                init_reg <= 1'b0;
            end
        end
    end

    assign status.init   = init_reg;
    assign result_strobe = strobe_reg;
    assign mask_word     = mask_word_reg;

endmodule

/* src/feature_exclusion_mask.sv */
// Feature exclusion mask top: front end, job queue, mask sequencer; two jobs can queue.
// A read job passes the queue, the sequencer's issue state, the RAM read register and the
// registered strobe; an add point reads and writes back each covered word of its patch in turn.
// Jobs do not overlap in the sequencer; a clear sweeps the whole mask at one mask word per cycle
// (the mask RAM takes one read and one write each cycle).
// Reset (async, active low) loads config defaults and runs a clearing pass over the mask with
// busy high; the receiver cannot stall, results are one-cycle strobes.
module feature_exclusion_mask
    import fem_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // command word
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                command,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic [RROW_W-1:0]         read_row,
    input  logic [RWORD_W-1:0]        read_word,
    // config write port
    input  logic                      cfg_write,
    input  logic [1:0]                cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    // result word
    output logic                      result_strobe,
    output logic [OUT_W-1:0]          mask_word
);

    logic         push;
    task_t        push_entry;
    task_t        head;
    logic         pop;
    q_status_t    q_stat;
    back_status_t bk_stat;

    // Stall commands while the queue is full or the power-up sweep runs.
    // Skipped points and unused codes are accepted and simply dropped.
    assign busy = q_stat.full || bk_stat.init;

    // Decode, clamp the patch to the image and split columns into words.
    fem_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .point_x   (point_x),
        .point_y   (point_y),
        .read_row  (read_row),
        .read_word (read_word),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .entry     (push_entry)
    );

    // Decouples the command side from long clear sweeps.
    fem_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_stat)
    );

    // Owns the mask RAM; jobs run strictly in order.
    fem_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_stat.empty),
        .head          (head),
        .pop           (pop),
        .status        (bk_stat),
        .result_strobe (result_strobe),
        .mask_word     (mask_word)
    );

endmodule

/* src/fem_checker.sv */
// Port-level checks for feature_exclusion_mask, bound to the top level.
// Depends on nothing but the top level's ports.
module fem_checker (
    input logic clk,
    input logic rst_n,
    input logic busy,
    input logic result_strobe
);

    // The power-up sweep holds off commands right after reset.
    a_busy_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> busy)
        else $error("busy low right after reset");

    a_no_result_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !result_strobe)
        else $error("result strobe right after reset");

    // A read passes the idle, issue and output states, so strobes are spaced.
    a_strobe_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |=> !result_strobe ##1 !result_strobe)
        else $error("result strobes too close");

endmodule

bind feature_exclusion_mask fem_checker u_fem_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .busy          (busy),
    .result_strobe (result_strobe)
);
